/* src/vfti_pkg.sv */
// vfti_pkg: shared types and constants of the trilinear vector field interpolator
// used by the channel interfaces, the vertex ram and the top level
`timescale 1ns / 1ps

package vfti_pkg;

  // payload formats
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 4;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int LANES      = 3;

  // grid defaults
  localparam int                MAX_DIM_DEFAULT = 16;
  localparam logic [SIZE_W-1:0] SIZE_RESET      = SIZE_W'(16);

  // widest x + y*sx + z*sx*sy for 4-bit indexes and 5-bit sizes stays below 2^14
  localparam int LIN_W = 14;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } act_t;

  typedef enum logic {
    STAT_DONE  = 1'b0,
    STAT_RANGE = 1'b1
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    act_t                         action;
    logic [IDX_W-1:0]             idx_x;
    logic [IDX_W-1:0]             idx_y;
    logic [IDX_W-1:0]             idx_z;
    logic [FRAC_BITS-1:0]         frac_x;
    logic [FRAC_BITS-1:0]         frac_y;
    logic [FRAC_BITS-1:0]         frac_z;
    logic signed [VALUE_BITS-1:0] value_0;
    logic signed [VALUE_BITS-1:0] value_1;
    logic signed [VALUE_BITS-1:0] value_2;
  } item_t;

  typedef struct packed {
    stat_t                        status;
    logic signed [VALUE_BITS-1:0] result_0;
    logic signed [VALUE_BITS-1:0] result_1;
    logic signed [VALUE_BITS-1:0] result_2;
  } result_t;

endpackage

/* src/vfti_ifs.sv */
// vfti channel interfaces: item input, result output and configuration write
// depends on vfti_pkg for payload types
`timescale 1ns / 1ps

interface vfti_item_if import vfti_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfti_result_if import vfti_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfti_cfg_if import vfti_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/vector_field_trilinear_interp.sv */
// vector_field_trilinear_interp: 3d grid of vectors with trilinear lookup
// write: the item goes to the hold state; the next item is taken once its result is loaded
// query: in the busy state the block makes eight corner reads on the one ram port and fourteen
//   lerp products per lane, then goes to the hold state; the next item waits until the result is loaded
// reset: sizes return to 16, control clears; vertex ram is not cleared
// depends on vfti_pkg, vfti_ifs and vfti_ram
`timescale 1ns / 1ps

module vector_field_trilinear_interp import vfti_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  vfti_cfg_if.sink      cfg,
  vfti_item_if.sink     item,
  vfti_result_if.source res
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int EXT_W  = (AW > LIN_W) ? AW : LIN_W;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int PROD_W = VALUE_BITS + WT_W + 1;
  localparam int MEM_W  = LANES * VALUE_BITS;
  localparam int OP_W   = 4;
  localparam int SLOTS  = 6;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam logic [OP_W-1:0]              LAST_OP = OP_W'(13);
  localparam logic [WT_W-1:0]              ONE     = WT_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0]     HALF    = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [VALUE_BITS-1:0] VMAX    = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN    = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BUSY = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
  } stage_t;

  state_t state;

  // configuration registers
  logic [SIZE_W-1:0] grid_size_x, grid_size_y, grid_size_z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size_x <= SIZE_RESET;
      grid_size_y <= SIZE_RESET;
      grid_size_z <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SIZE_X: grid_size_x <= cfg.data;
        CFG_SIZE_Y: grid_size_y <= cfg.data;
        CFG_SIZE_Z: grid_size_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // sizes above the grid capacity count as the capacity
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    return (int'(s) > MAX_DIM) ? SIZE_W'(MAX_DIM) : s;
  endfunction

  logic [SIZE_W-1:0]   sx, sy, sz;
  logic [2*SIZE_W-1:0] stride_z_c;

  assign sx         = clamp_size(grid_size_x);
  assign sy         = clamp_size(grid_size_y);
  assign sz         = clamp_size(grid_size_z);
  assign stride_z_c = sx * sy;

  // input decode and range checks
  logic             item_fire, is_query, wr_ok, qry_ok, mem_we, start_query;
  logic [EXT_W-1:0] lin_addr_c;

  assign item.ready = (state == ST_IDLE);
  assign item_fire  = item.valid && item.ready;
  assign is_query   = (item.data.action == ACT_QUERY);

  assign wr_ok = ({1'b0, item.data.idx_x} < sx) && ({1'b0, item.data.idx_y} < sy) &&
                 ({1'b0, item.data.idx_z} < sz);
  assign qry_ok = (({1'b0, item.data.idx_x} + SIZE_W'(1)) < sx) &&
                  (({1'b0, item.data.idx_y} + SIZE_W'(1)) < sy) &&
                  (({1'b0, item.data.idx_z} + SIZE_W'(1)) < sz);

  assign lin_addr_c = EXT_W'(item.data.idx_x) +
                      EXT_W'(item.data.idx_y) * EXT_W'(sx) +
                      EXT_W'(item.data.idx_z) * EXT_W'(stride_z_c);

  assign mem_we      = item_fire && !is_query && wr_ok;
  assign start_query = item_fire && is_query && qry_ok;

  // query context captured at transfer
  logic [EXT_W-1:0]     base_q;
  logic [SIZE_W-1:0]    stride_y_q;
  logic [2*SIZE_W-1:0]  stride_z_q;
  logic [FRAC_BITS-1:0] kx_q, ky_q, kz_q;

  always_ff @(posedge clk) begin
    if (start_query) begin
      base_q     <= lin_addr_c;
      stride_y_q <= sx;
      stride_z_q <= stride_z_c;
      kx_q       <= item.data.frac_x;
      ky_q       <= item.data.frac_y;
      kz_q       <= item.data.frac_z;
    end
  end

  // op sequencer: ops 0..7 read corners (bit0 dx, bit1 dz, bit2 dy),
  // ops 8..13 reuse partial lerps, pairs of ops make one lerp
  logic            issuing;
  logic [OP_W-1:0] step;
  stage_t          s1, s2;
  logic            q_done, out_load, res_valid;

  assign q_done   = s2.valid && (s2.op == LAST_OP);
  assign out_load = (state == ST_HOLD) && (!res_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issuing   <= 1'b0;
      step      <= '0;
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1.valid <= issuing;
      s1.op    <= step;
      s2       <= s1;

      if (start_query) begin
        issuing <= 1'b1;
        step    <= '0;
      end else if (issuing) begin
        if (step == LAST_OP) begin
          issuing <= 1'b0;
        end else begin
          step <= step + OP_W'(1);
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            state <= start_query ? ST_BUSY : ST_HOLD;
          end
        end
        ST_BUSY: begin
          if (q_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // vertex ram: one entry holds all three components
  logic [EXT_W-1:0] corner_addr;
  logic [AW-1:0]    mem_addr;
  logic [MEM_W-1:0] mem_wdata, mem_rdata;

  assign corner_addr = base_q + EXT_W'(step[0]) +
                       (step[2] ? EXT_W'(stride_y_q) : EXT_W'(0)) +
                       (step[1] ? EXT_W'(stride_z_q) : EXT_W'(0));
  assign mem_addr    = issuing ? corner_addr[AW-1:0] : lin_addr_c[AW-1:0];
  assign mem_wdata   = {item.data.value_2, item.data.value_1, item.data.value_0};

  vfti_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // lerp weight: ops 0..7 use kx, 8..11 kz, 12 and 13 ky; odd ops take k, even 1-k
  logic [FRAC_BITS-1:0] frac_sel;
  logic [WT_W-1:0]      weight;

  always_comb begin
    if (!s1.op[3]) begin
      frac_sel = kx_q;
    end else if (s1.op[2]) begin
      frac_sel = ky_q;
    end else begin
      frac_sel = kz_q;
    end
    weight = s1.op[0] ? {1'b0, frac_sel} : ONE - {1'b0, frac_sel};
  end

  // per component lanes: multiply and round, then pair sum with saturation
  logic signed [VALUE_BITS-1:0] operand    [LANES];
  logic signed [PROD_W-1:0]     prod_full  [LANES];
  logic signed [PROD_W-1:0]     prod_sh    [LANES];
  logic signed [VALUE_BITS-1:0] prod_round [LANES];
  logic signed [VALUE_BITS:0]   sum        [LANES];
  logic signed [VALUE_BITS-1:0] sat        [LANES];
  logic signed [VALUE_BITS-1:0] prod_q     [LANES];
  logic signed [VALUE_BITS-1:0] first_q    [LANES];
  logic signed [VALUE_BITS-1:0] slot       [LANES][SLOTS];
  logic signed [VALUE_BITS-1:0] pend_val   [LANES];
  stat_t                        pend_status;
  result_t                      out_q;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      operand[c]    = s1.op[3] ? slot[c][s1.op[SLOT_W-1:0]]
                               : mem_rdata[c*VALUE_BITS +: VALUE_BITS];
      prod_full[c]  = operand[c] * signed'({1'b0, weight});
      prod_sh[c]    = (prod_full[c] + HALF) >>> FRAC_BITS;
      prod_round[c] = prod_sh[c][VALUE_BITS-1:0];
      sum[c]        = {first_q[c][VALUE_BITS-1], first_q[c]} +
                      {prod_q[c][VALUE_BITS-1], prod_q[c]};
      if (sum[c][VALUE_BITS] != sum[c][VALUE_BITS-1]) begin
        sat[c] = sum[c][VALUE_BITS] ? VMIN : VMAX;
      end else begin
        sat[c] = sum[c][VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < LANES; c++) begin
      if (s1.valid) begin
        prod_q[c] <= prod_round[c];
      end
      // even op holds its product, odd op closes the lerp into a slot, the last one into the pending result
      if (s2.valid) begin
        if (!s2.op[0]) begin
          first_q[c] <= prod_q[c];
        end else if (s2.op != LAST_OP) begin
          slot[c][s2.op[SLOT_W:1]] <= sat[c];
        end
      end
      if (item_fire) begin
        pend_val[c] <= '0;
      end else if (q_done) begin
        pend_val[c] <= sat[c];
      end
    end
  end

  // result status and output register
  always_ff @(posedge clk) begin
    if (item_fire) begin
      if (is_query) begin
        pend_status <= qry_ok ? STAT_DONE : STAT_RANGE;
      end else begin
        pend_status <= wr_ok ? STAT_DONE : STAT_RANGE;
      end
    end
    if (out_load) begin
      out_q.status   <= pend_status;
      out_q.result_0 <= pend_val[0];
      out_q.result_1 <= pend_val[1];
      out_q.result_2 <= pend_val[2];
    end
  end

  assign res.valid = res_valid;
  assign res.data  = out_q;

  // no item is taken while a query is still in the pipe
  a_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> (!issuing && !s1.valid && !s2.valid))
    else $error("item ready while query ops in flight");

  // every multiplied op reaches the sum stage in the next cycle
  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    s1.valid |=> (s2.valid && (s2.op == $past(s1.op))))
    else $error("op lost between multiply and sum stages");

  // a new result comes only out of the hold state
  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_HOLD))
    else $error("result loaded outside hold state");

endmodule

/* src/vfti_ram.sv */
// vfti_ram: generic single-port ram with registered read data
// depends on vfti_pkg for default sizes
`timescale 1ns / 1ps

module vfti_ram import vfti_pkg::*; #(
  parameter int WIDTH = LANES * VALUE_BITS,
  parameter int DEPTH = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT * MAX_DIM_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read data registered and available in the cycle after the access
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
